>>> hdl/bss_pkg.sv
package bss_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CfgLower   = 2'd0;
    localparam logic [1:0] CfgUpper   = 2'd1;
    localparam logic [1:0] CfgFalloff = 2'd2;

    localparam logic signed [31:0] LowerReset   = -32'sd65536;
    localparam logic signed [31:0] UpperReset   = 32'sd65536;
    localparam logic [30:0]        FalloffReset = 31'd0;

    // 1.0 in Q0.32
    localparam logic [32:0] SOne = 33'h1_0000_0000;

    typedef struct packed {
        logic signed [31:0] lower;
        logic signed [31:0] upper;
        logic [30:0]        falloff;
    } cfg_t;

    // Divider operands and the blend endpoints riding along
    typedef struct packed {
        logic [31:0]        num;
        logic [31:0]        den;
        logic [31:0]        quo;
        logic signed [31:0] from_v;
        logic signed [31:0] to_v;
    } dv_t;

    // S-curve weight and difference magnitude for the final blend
    typedef struct packed {
        logic [32:0]        s;
        logic [32:0]        mag;
        logic               neg;
        logic signed [31:0] from_v;
    } bl_t;

endpackage

>>> hdl/bss_front.sv
module bss_front (
    input  logic               clk,
    input  logic               rst_n,
    input  bss_pkg::cfg_t      cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] control_value,
    input  logic signed [31:0] source_a,
    input  logic signed [31:0] source_b,
    output logic               out_valid,
    input  logic               out_ready,
    output bss_pkg::dv_t       out_data
);
    import bss_pkg::*;

    logic [2:0] vld_reg;
    logic [3:0] rdy;

    // stage 1: raw request
    logic signed [31:0] c1_reg, a1_reg, b1_reg;
    // stage 2: offsets from the bounds, clamped falloff
    logic signed [32:0] cl_reg, cu_reg;
    logic signed [32:0] cl_next, cu_next;
    logic [30:0]        f2_reg, f_next;
    logic signed [31:0] a2_reg, b2_reg;
    logic signed [32:0] diff;
    logic [30:0]        half;
    // stage 3: offsets shifted by the falloff
    logic signed [33:0] t1_reg, t2_reg, t1_next, t2_next;
    logic [30:0]        f3_reg;
    logic               band_reg, band_next;
    logic signed [31:0] a3_reg, b3_reg;

    logic [31:0] den2;
    logic        t1_lt, t2_lt;

    assign rdy[3] = out_ready;
    assign rdy[2] = !vld_reg[2] || rdy[3];
    assign rdy[1] = !vld_reg[1] || rdy[2];
    assign rdy[0] = !vld_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[2];

    always_comb
    begin
        diff = {cfg.upper[31], cfg.upper} - {cfg.lower[31], cfg.lower};
        if (!diff[32] && (diff != 33'sd0))
            half = diff[31:1];
        else
            half = 31'd0;
        f_next  = (cfg.falloff < half) ? cfg.falloff : half;
        cl_next = {c1_reg[31], c1_reg} - {cfg.lower[31], cfg.lower};
        cu_next = {c1_reg[31], c1_reg} - {cfg.upper[31], cfg.upper};
    end

    always_comb
    begin
        t1_next   = {cl_reg[32], cl_reg} + $signed({3'b000, f2_reg});
        t2_next   = {cu_reg[32], cu_reg} + $signed({3'b000, f2_reg});
        band_next = !cl_reg[32] && (cu_reg[32] || (cu_reg == 33'sd0));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 3'b000;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0];
            if (rdy[2])
                vld_reg[2] <= vld_reg[1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            c1_reg <= control_value;
            a1_reg <= source_a;
            b1_reg <= source_b;
        end
        if (rdy[1] && vld_reg[0])
        begin
            cl_reg <= cl_next;
            cu_reg <= cu_next;
            f2_reg <= f_next;
            a2_reg <= a1_reg;
            b2_reg <= b1_reg;
        end
        if (rdy[2] && vld_reg[1])
        begin
            t1_reg   <= t1_next;
            t2_reg   <= t2_next;
            f3_reg   <= f2_reg;
            band_reg <= band_next;
            a3_reg   <= a2_reg;
            b3_reg   <= b2_reg;
        end
    end

    // Region select. Plain passes go through the divider as 0/1 with equal
    // endpoints, so they come out of the blend unchanged.
    always_comb
    begin
        den2  = {f3_reg, 1'b0};
        t1_lt = t1_reg < $signed({2'b00, den2});
        t2_lt = t2_reg < $signed({2'b00, den2});

        out_data.num    = 32'd0;
        out_data.den    = 32'd1;
        out_data.quo    = 32'd0;
        out_data.from_v = a3_reg;
        out_data.to_v   = a3_reg;

        if (f3_reg == 31'd0)
        begin
            if (band_reg)
            begin
                out_data.from_v = b3_reg;
                out_data.to_v   = b3_reg;
            end
        end
        else if (t1_reg[33])
        begin
            // below the rising edge: source A
        end
        else if (t1_lt)
        begin
            out_data.num    = t1_reg[31:0];
            out_data.den    = den2;
            out_data.from_v = a3_reg;
            out_data.to_v   = b3_reg;
        end
        else if (t2_reg[33])
        begin
            out_data.from_v = b3_reg;
            out_data.to_v   = b3_reg;
        end
        else if (t2_lt)
        begin
            out_data.num    = t2_reg[31:0];
            out_data.den    = den2;
            out_data.from_v = b3_reg;
            out_data.to_v   = a3_reg;
        end
    end

endmodule

>>> hdl/bss_div.sv
module bss_div (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bss_pkg::dv_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output bss_pkg::dv_t out_data
);
    import bss_pkg::*;

    localparam int BitsPerStage = 4;
    localparam int Stages       = 32 / BitsPerStage;

    // Restoring division, a few quotient bits per stage
    function automatic dv_t div_step(input dv_t x);
        dv_t         y;
        logic [32:0] r2;
        y = x;
        for (int i = 0; i < BitsPerStage; i++)
        begin
            r2 = {y.num, 1'b0};
            if (r2 >= {1'b0, y.den})
            begin
                y.num = 32'(r2 - {1'b0, y.den});
                y.quo = {y.quo[30:0], 1'b1};
            end
            else
            begin
                y.num = r2[31:0];
                y.quo = {y.quo[30:0], 1'b0};
            end
        end
        return y;
    endfunction

    logic [Stages-1:0] vld_reg;
    logic [Stages:0]   rdy;
    dv_t               stg_reg [Stages];

    assign rdy[Stages] = out_ready;
    assign in_ready    = rdy[0];
    assign out_valid   = vld_reg[Stages-1];
    assign out_data    = stg_reg[Stages-1];

    for (genvar k = 0; k < Stages; k++)
    begin : g_stage
        logic vin;
        dv_t  stg_next;

        assign rdy[k] = !vld_reg[k] || rdy[k+1];

        if (k == 0)
        begin : g_first
            assign vin      = in_valid;
            assign stg_next = div_step(in_data);
        end
        else
        begin : g_rest
            assign vin      = vld_reg[k-1];
            assign stg_next = div_step(stg_reg[k-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[k] <= 1'b0;
            else if (rdy[k])
                vld_reg[k] <= vin;
        end

        always_ff @(posedge clk)
        begin
            if (rdy[k] && vin)
                stg_reg[k] <= stg_next;
        end
    end

endmodule

>>> hdl/bss_curve.sv
module bss_curve (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  bss_pkg::dv_t in_data,
    output logic         out_valid,
    input  logic         out_ready,
    output bss_pkg::bl_t out_data
);
    import bss_pkg::*;

    logic [1:0] vld_reg;
    logic [2:0] rdy;

    logic [63:0]        sq_full, cb_full;
    logic [31:0]        al1_reg, sq1_reg;
    logic signed [31:0] from1_reg, to1_reg;
    logic [31:0]        sq2_reg, cb2_reg;
    logic signed [31:0] from2_reg, to2_reg;

    logic [33:0]        s_raw;
    logic signed [32:0] d;

    assign rdy[2]    = out_ready;
    assign rdy[1]    = !vld_reg[1] || rdy[2];
    assign rdy[0]    = !vld_reg[0] || rdy[1];
    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[1];

    assign sq_full = in_data.quo * in_data.quo;
    assign cb_full = sq1_reg * al1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 2'b00;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            al1_reg   <= in_data.quo;
            sq1_reg   <= sq_full[63:32];
            from1_reg <= in_data.from_v;
            to1_reg   <= in_data.to_v;
        end
        if (rdy[1] && vld_reg[0])
        begin
            sq2_reg   <= sq1_reg;
            cb2_reg   <= cb_full[63:32];
            from2_reg <= from1_reg;
            to2_reg   <= to1_reg;
        end
    end

    // s = 3a^2 - 2a^3, never above 1.0
    always_comb
    begin
        s_raw = ({2'b00, sq2_reg} + {1'b0, sq2_reg, 1'b0}) - {1'b0, cb2_reg, 1'b0};
        d     = {to2_reg[31], to2_reg} - {from2_reg[31], from2_reg};

        out_data.s      = (s_raw > {1'b0, SOne}) ? SOne : s_raw[32:0];
        out_data.neg    = d[32];
        out_data.mag    = d[32] ? 33'(-d) : 33'(d);
        out_data.from_v = from2_reg;
    end

endmodule

>>> hdl/bss_blend.sv
module bss_blend (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bss_pkg::bl_t       in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_value
);
    import bss_pkg::*;

    logic [1:0] vld_reg;
    logic [2:0] rdy;

    logic [49:0]        p_hi_next, p_hi_reg;
    logic [48:0]        p_lo_full;
    logic [32:0]        p_lo_reg;
    logic               neg_reg;
    logic signed [31:0] from_reg;

    logic [50:0]        m;
    logic [34:0]        r;
    logic signed [36:0] sum;
    logic signed [31:0] res_next, res_reg;

    assign rdy[2]       = out_ready;
    assign rdy[1]       = !vld_reg[1] || rdy[2];
    assign rdy[0]       = !vld_reg[0] || rdy[1];
    assign in_ready     = rdy[0];
    assign out_valid    = vld_reg[1];
    assign result_value = res_reg;

    assign p_hi_next = in_data.mag * in_data.s[32:16];
    assign p_lo_full = in_data.mag * in_data.s[15:0];

    always_comb
    begin
        m = {1'b0, p_hi_reg} + {18'd0, p_lo_reg};
        r = 35'((m + 51'h8000) >> 16);
        if (neg_reg)
            sum = {{5{from_reg[31]}}, from_reg} - $signed({2'b00, r});
        else
            sum = {{5{from_reg[31]}}, from_reg} + $signed({2'b00, r});
        if (sum > 37'sd2147483647)
            res_next = 32'sh7FFF_FFFF;
        else if (sum < -37'sd2147483648)
            res_next = 32'sh8000_0000;
        else
            res_next = sum[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 2'b00;
        end
        else
        begin
            if (rdy[0])
                vld_reg[0] <= in_valid;
            if (rdy[1])
                vld_reg[1] <= vld_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0] && in_valid)
        begin
            p_hi_reg <= p_hi_next;
            p_lo_reg <= p_lo_full[48:16];
            neg_reg  <= in_data.neg;
            from_reg <= in_data.from_v;
        end
        if (rdy[1] && vld_reg[0])
            res_reg <= res_next;
    end

endmodule

>>> hdl/banded_select_with_smooth_edges.sv
// Banded select with S-curve edges, signed Q16.16. Takes one request per
// clock while the output is not stalled, through 15 register stages: 3
// stages of band compare and region select, 8 stages of the 32-bit
// fraction divider (4 quotient bits per stage), 2 stages for a^2, a^3 and
// the curve, and 2 for the blend multiply and rounding. Every stage holds
// its own valid bit, so a stalled output only backs up as far as the
// pipeline is full. Configuration writes are always ready and take effect
// for requests accepted after them; write only while no request is in flight.
module banded_select_with_smooth_edges (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] control_value,
    input  logic signed [31:0] source_a,
    input  logic signed [31:0] source_b,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] result_value
);
    import bss_pkg::*;

    cfg_t cfg_reg;

    logic fr_valid, fr_ready;
    dv_t  fr_data;
    logic dv_valid, dv_ready;
    dv_t  dv_data;
    logic cv_valid, cv_ready;
    bl_t  cv_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lower   <= LowerReset;
            cfg_reg.upper   <= UpperReset;
            cfg_reg.falloff <= FalloffReset;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CfgLower:   cfg_reg.lower   <= cfg_data;
                CfgUpper:   cfg_reg.upper   <= cfg_data;
                CfgFalloff: cfg_reg.falloff <= cfg_data[30:0];
                default:    ;
            endcase
        end
    end

    bss_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .control_value (control_value),
        .source_a      (source_a),
        .source_b      (source_b),
        .out_valid     (fr_valid),
        .out_ready     (fr_ready),
        .out_data      (fr_data)
    );

    bss_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_data  (dv_data)
    );

    bss_curve u_curve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_data   (dv_data),
        .out_valid (cv_valid),
        .out_ready (cv_ready),
        .out_data  (cv_data)
    );

    bss_blend u_blend (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (cv_valid),
        .in_ready     (cv_ready),
        .in_data      (cv_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value)
    );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import bss_pkg::*;

    localparam logic signed [31:0] QMax = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] QMin = 32'sh8000_0000;
    // Index past the register list, must be ignored by the block
    localparam logic [1:0] CfgUnused = 2'd3;
    localparam int StallLimit = 4000;
    localparam int PhaseCount = 12;
    localparam int ReqsPerPhase = 58;

    typedef enum logic {RowWrite, RowSend} row_kind_e;

    typedef struct {
        row_kind_e          kind;
        logic [1:0]         idx;
        logic [31:0]        word;
        logic signed [31:0] c;
        logic signed [31:0] sa;
        logic signed [31:0] sb;
        bit                 known;
        logic signed [31:0] target;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = CfgLower;
    logic [31:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic signed [31:0] control_value = '0;
    logic signed [31:0] source_a = '0;
    logic signed [31:0] source_b = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] result_value;

    // Side info riding with each request: a hand-written expectation, if any
    bit                 req_known = 1'b0;
    logic signed [31:0] req_target = '0;

    // Register copies as seen by the predictor
    logic signed [31:0] band_lo = LowerReset;
    logic signed [31:0] band_hi = UpperReset;
    logic [30:0]        band_falloff = FalloffReset;

    logic signed [31:0] predicted_values[$];
    dir_row_t           dir_rows[$];
    int                 mismatches = 0;
    int                 stall_cycles = 0;
    int                 in_idle_pct = 20;
    int                 out_idle_pct = 70;

    banded_select_with_smooth_edges dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .control_value (control_value),
        .source_a      (source_a),
        .source_b      (source_b),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .result_value  (result_value)
    );

    always #6 clk = ~clk;

    function automatic logic signed [31:0] clip32(input longint v);
        if (v > longint'(QMax))
            return QMax;
        if (v < longint'(QMin))
            return QMin;
        return v[31:0];
    endfunction

    // S-curve blend from from_v toward to_v, weight from num / den
    function automatic longint smooth_mix(input longint from_v, input longint to_v,
                                          input logic [63:0] num, input logic [63:0] den);
        logic [63:0] alpha;
        logic [63:0] a2;
        logic [63:0] a3;
        logic [63:0] s;
        logic [63:0] mag;
        logic [63:0] prod;
        longint      diff;
        alpha = (num << 32) / den;
        a2 = (alpha * alpha) >> 32;
        a3 = (a2 * alpha) >> 32;
        s = 64'd3 * a2 - 64'd2 * a3;
        if (s > 64'(SOne))
            s = 64'(SOne);
        diff = to_v - from_v;
        mag = (diff < 0) ? 64'(-diff) : 64'(diff);
        prod = mag * (s >> 16) + ((mag * (s & 64'hFFFF)) >> 16);
        prod = (prod + 64'h8000) >> 16;
        return (diff < 0) ? from_v - longint'(prod) : from_v + longint'(prod);
    endfunction

    function automatic logic signed [31:0] band_select(input logic signed [31:0] ctl_in,
                                                       input logic signed [31:0] src_a,
                                                       input logic signed [31:0] src_b);
        longint ctl;
        longint lo;
        longint hi;
        longint half;
        longint f;
        longint res;
        ctl = ctl_in;
        lo = band_lo;
        hi = band_hi;
        half = (hi > lo) ? (hi - lo) / 2 : 0;
        f = (longint'(band_falloff) < half) ? longint'(band_falloff) : half;
        if (f == 0)
            res = (ctl < lo || ctl > hi) ? longint'(src_a) : longint'(src_b);
        else if (ctl < lo - f)
            res = src_a;
        else if (ctl < lo + f)
            res = smooth_mix(src_a, src_b, 64'(ctl - lo + f), 64'(2 * f));
        else if (ctl < hi - f)
            res = src_b;
        else if (ctl < hi + f)
            res = smooth_mix(src_b, src_a, 64'(ctl - hi + f), 64'(2 * f));
        else
            res = src_a;
        return clip32(res);
    endfunction

    function automatic logic signed [31:0] rnd_source();
        case ($urandom_range(19))
            0: return QMax;
            1: return QMin;
            default: return $urandom;
        endcase
    endfunction

    function automatic void cfg_row(input logic [1:0] idx, input logic [31:0] word);
        dir_row_t r;
        r = '{RowWrite, idx, word, 32'sd0, 32'sd0, 32'sd0, 1'b0, 32'sd0};
        dir_rows.push_back(r);
    endfunction

    function automatic void req_row(input logic signed [31:0] c, input logic signed [31:0] sa,
                                    input logic signed [31:0] sb, input bit known,
                                    input logic signed [31:0] target);
        dir_row_t r;
        r = '{RowSend, CfgLower, 32'd0, c, sa, sb, known, target};
        dir_rows.push_back(r);
    endfunction

    task automatic send_req(input logic signed [31:0] c, input logic signed [31:0] sa,
                            input logic signed [31:0] sb, input bit known,
                            input logic signed [31:0] target);
        cfg_valid <= 1'b0;
        while ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        control_value <= c;
        source_a <= sa;
        source_b <= sb;
        req_known <= known;
        req_target <= target;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    // Stop sending and wait until every request in flight has come back
    task automatic drain();
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (predicted_values.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= out_idle_pct);

    always @(posedge clk) begin
        logic signed [31:0] want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CfgLower:   band_lo = cfg_data;
                    CfgUpper:   band_hi = cfg_data;
                    CfgFalloff: band_falloff = cfg_data[30:0];
                    default:    ;
                endcase
            end
            if (in_valid && in_ready)
                predicted_values.push_back(req_known ? req_target
                                           : band_select(control_value, source_a, source_b));
            if (out_valid && out_ready) begin
                if (predicted_values.size() == 0) begin
                    if (mismatches < 10)
                        $display("unexpected result 0x%08h at %0t", result_value, $realtime);
                    mismatches++;
                end else begin
                    want = predicted_values.pop_front();
                    if (result_value !== want) begin
                        if (mismatches < 10)
                            $display("result_value mismatch at %0t: expected %0d (0x%08h), got %0d (0x%08h)",
                                     $realtime, want, want, result_value, result_value);
                        mismatches++;
                    end
                end
            end
        end
        if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
    end

    initial begin
        while (stall_cycles < StallLimit)
            @(posedge clk);
        $display("watchdog: no request moved for %0d cycles", StallLimit);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        dir_row_t           row;
        row_kind_e          prev_kind;
        longint             lo_l;
        longint             hi_l;
        longint             half;
        longint             eff;
        longint             c_l;
        logic [30:0]        fo;
        logic signed [31:0] lo32;
        logic signed [31:0] hi32;

        // Reset band is [-1.0, 1.0] with hard edges
        req_row(32'sd0, 32'sd100, 32'sd200, 1'b1, 32'sd200);
        req_row(-32'sd65536, 32'sd1, 32'sd2, 1'b1, 32'sd2);
        req_row(32'sd65536, 32'sd1, 32'sd2, 1'b1, 32'sd2);
        req_row(-32'sd65537, 32'sd1, 32'sd2, 1'b1, 32'sd1);
        req_row(32'sd65537, 32'sd1, 32'sd2, 1'b1, 32'sd1);
        req_row(QMin, QMax, QMin, 1'b1, QMax);
        req_row(QMax, QMin, QMax, 1'b1, QMin);
        // Falloff 0.5: zones [-1.5, -0.5) and [0.5, 1.5)
        cfg_row(CfgFalloff, 32'h0000_8000);
        req_row(-32'sd98305, 32'sd1000, -32'sd1000, 1'b1, 32'sd1000);
        req_row(-32'sd98304, 32'sd1000, -32'sd1000, 1'b1, 32'sd1000);
        req_row(-32'sd65536, QMin, QMax, 1'b0, 32'sd0);
        req_row(-32'sd32769, 32'sh1234_5678, -32'sh0ABC_DEF0, 1'b0, 32'sd0);
        req_row(-32'sd32768, 32'sd1000, -32'sd1000, 1'b1, -32'sd1000);
        req_row(32'sd32768, 32'sd1000, -32'sd1000, 1'b1, -32'sd1000);
        req_row(32'sd98303, QMin, QMax, 1'b0, 32'sd0);
        req_row(32'sd98304, 32'sd1000, -32'sd1000, 1'b1, 32'sd1000);
        // Oversized falloff gets clamped to half the band; stray index ignored
        cfg_row(CfgFalloff, 32'hFFFF_FFFF);
        cfg_row(CfgUnused, 32'h0000_0000);
        req_row(-32'sd1, 32'sd458752, -32'sd196608, 1'b0, 32'sd0);
        req_row(32'sd0, 32'sd5, 32'sd9, 1'b1, 32'sd9);
        // Full-range band
        cfg_row(CfgLower, QMin);
        cfg_row(CfgUpper, QMax);
        req_row(QMin, QMax, QMin, 1'b0, 32'sd0);
        req_row(QMax, QMin, QMax, 1'b0, 32'sd0);
        req_row(-32'sd1, 32'sd123, 32'sd456, 1'b0, 32'sd0);
        // Reversed band: nothing inside
        cfg_row(CfgLower, 32'sd655360);
        cfg_row(CfgUpper, -32'sd655360);
        req_row(32'sd0, 32'sd11, 32'sd22, 1'b1, 32'sd11);
        req_row(32'sd655360, 32'sd11, 32'sd22, 1'b1, 32'sd11);
        // Single-point band
        cfg_row(CfgUpper, 32'sd655360);
        req_row(32'sd655360, 32'sd11, 32'sd22, 1'b0, 32'sd0);
        req_row(32'sd655361, 32'sd11, 32'sd22, 1'b1, 32'sd11);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        prev_kind = RowWrite;
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.kind == RowWrite) begin
                if (prev_kind == RowSend)
                    drain();
                write_reg(row.idx, row.word);
            end else begin
                send_req(row.c, row.sa, row.sb, row.known, row.target);
            end
            prev_kind = row.kind;
        end

        for (int ph = 0; ph < PhaseCount; ph++) begin
            case (ph / 4)
                0: begin in_idle_pct = 20; out_idle_pct = 70; end
                1: begin in_idle_pct = 70; out_idle_pct = 20; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            case (ph % 6)
                0: begin
                    lo_l = longint'(rnd_source());
                    hi_l = lo_l + longint'($urandom_range(1, 1 << 20));
                    fo = 31'($urandom_range(0, 1 << 21));
                end
                1: begin
                    lo_l = -longint'($urandom_range(0, 1 << 24));
                    hi_l = longint'($urandom_range(1, 1 << 24));
                    fo = 31'($urandom_range(0, 1 << 23));
                end
                2: begin
                    lo_l = QMin;
                    hi_l = QMax;
                    fo = (ph < 6) ? 31'h7FFF_FFFF : 31'($urandom);
                end
                3: begin
                    lo_l = longint'(rnd_source());
                    hi_l = lo_l - longint'($urandom_range(0, 4));
                    fo = 31'($urandom_range(0, 1 << 16));
                end
                4: begin
                    lo_l = -longint'($urandom_range(0, 1 << 20));
                    hi_l = longint'($urandom_range(0, 1 << 20));
                    fo = '0;
                end
                default: begin
                    lo_l = longint'(rnd_source());
                    hi_l = longint'(rnd_source());
                    fo = 31'($urandom);
                end
            endcase
            lo32 = clip32(lo_l);
            hi32 = clip32(hi_l);
            lo_l = lo32;
            hi_l = hi32;
            half = (hi_l > lo_l) ? (hi_l - lo_l) / 2 : 0;
            eff = (longint'(fo) < half) ? longint'(fo) : half;

            drain();
            write_reg(CfgLower, lo32);
            write_reg(CfgUpper, hi32);
            write_reg(CfgFalloff, {1'b0, fo});

            for (int n = 0; n < ReqsPerPhase; n++) begin
                case ($urandom_range(9))
                    0, 1, 2: c_l = lo_l + longint'({$urandom, $urandom} % 64'(2 * eff + 17))
                                   - (eff + 8);
                    3, 4, 5: c_l = hi_l + longint'({$urandom, $urandom} % 64'(2 * eff + 17))
                                   - (eff + 8);
                    6: begin
                        case ($urandom_range(5))
                            0: c_l = lo_l - eff;
                            1: c_l = lo_l + eff;
                            2: c_l = hi_l - eff;
                            3: c_l = hi_l + eff;
                            4: c_l = lo_l;
                            default: c_l = hi_l;
                        endcase
                    end
                    default: c_l = longint'(rnd_source());
                endcase
                send_req(clip32(c_l), rnd_source(), rnd_source(), 1'b0, 32'sd0);
            end
        end

        drain();
        repeat (32) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> banded_select_with_smooth_edges.f
hdl/bss_pkg.sv
hdl/bss_front.sv
hdl/bss_div.sv
hdl/bss_curve.sv
hdl/bss_blend.sv
hdl/banded_select_with_smooth_edges.sv
tb/tb.sv
